@@ src/lkv_pkg.sv @@
package lkv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [CAP_W-1:0]         cap_t;

endpackage

@@ src/lkv_ifs.sv @@
interface lkv_req_if;
	logic              valid;
	logic              ready;
	lkv_pkg::op_t      operation;
	lkv_pkg::word_t    key;
	lkv_pkg::word_t    write_value;

	modport source (output valid, operation, key, write_value, input ready);
	modport sink (input valid, operation, key, write_value, output ready);
endinterface

interface lkv_rsp_if;
	logic              valid;
	logic              ready;
	logic              hit;
	lkv_pkg::word_t    read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if;
	logic              valid;
	logic              ready;
	lkv_pkg::cap_t     capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

@@ src/lru_key_value_cache.sv @@
// Fully associative key-value cache with LRU replacement. A request (get or put) is
// registered on transfer, compared against every stored key in parallel in the next
// cycle, and its response lands in an output register; throughput is one request
// per cycle while the response side does not stall, and the response is registered
// from the request stage once the output register is free or being taken. The
// cycle time is set by the single-pass 32-bit key compare across all ENTRIES slots
// plus the recency-rank update. Writing capacity (0 acts as 1, values above ENTRIES
// saturate) empties the cache at once; there is no clearing pass after reset. Only
// write capacity while no request is in flight.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	lkv_req_if.sink        req,
	lkv_rsp_if.source      rsp,
	lkv_cfg_if.sink        cfg
);

	localparam int RANK_W = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// control state
	logic [ENTRIES-1:0]  valid_q;
	rank_t               rank_q [ENTRIES];
	cnt_t                used_q;
	lkv_pkg::cap_t       cap_q;
	logic                valid_s1;
	logic                out_valid_q;

	// payload
	lkv_pkg::word_t      key_q [ENTRIES];
	lkv_pkg::word_t      val_q [ENTRIES];
	lkv_pkg::op_t        op_s1;
	lkv_pkg::word_t      key_s1;
	lkv_pkg::word_t      wval_s1;
	logic                hit_q;
	lkv_pkg::word_t      rval_q;

	logic                cfg_fire;
	logic                req_fire;
	logic                advance;
	logic [ENTRIES-1:0]  hit_oh;
	logic [ENTRIES-1:0]  evict_oh;
	logic [ENTRIES-1:0]  free_oh;
	logic [ENTRIES-1:0]  slot_oh;
	logic [ENTRIES-1:0]  inv;
	logic                hit_any;
	rank_t               hit_rank;
	lkv_pkg::word_t      hit_val;
	rank_t               last_rank;
	logic [CMP_W-1:0]    eff_cap;
	logic                full;
	logic                do_insert;

	assign cfg.ready   = 1'b1;
	assign cfg_fire    = cfg.valid;
	assign advance     = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready   = !valid_s1 || advance;
	assign req_fire    = req.valid && req.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = rval_q;

	always_comb begin
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i] = valid_q[i] && (key_q[i] == key_s1);
			if (hit_oh[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_val  = hit_val | val_q[i];
			end
		end
		hit_any = |hit_oh;
	end

	// ranks of valid entries always form 0..used-1, so the LRU entry has rank used-1
	always_comb begin
		last_rank = RANK_W'(used_q - cnt_t'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			evict_oh[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	always_comb begin
		inv     = ~valid_q;
		free_oh = inv & (~inv + ENTRIES'(1));
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
		full      = CMP_W'(used_q) >= eff_cap;
		slot_oh   = full ? evict_oh : free_oh;
		do_insert = !hit_any && (op_s1 == lkv_pkg::OP_PUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			used_q      <= '0;
			cap_q       <= lkv_pkg::CAP_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_fire) begin
				cap_q   <= cfg.capacity;
				valid_q <= '0;
				used_q  <= '0;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_q[i] <= '0;
				end
			end else if (advance && hit_any) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit_oh[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + rank_t'(1);
					end
				end
			end else if (advance && do_insert) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_oh[i]) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + rank_t'(1);
					end
				end
				if (!full) begin
					used_q <= used_q + cnt_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1   <= req.operation;
			key_s1  <= req.key;
			wval_s1 <= req.write_value;
		end
		if (advance) begin
			hit_q  <= hit_any;
			rval_q <= (hit_any && (op_s1 == lkv_pkg::OP_GET)) ? hit_val : '0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_insert && slot_oh[i]) begin
					key_q[i] <= key_s1;
					val_q[i] <= wval_s1;
				end else if (hit_oh[i] && (op_s1 == lkv_pkg::OP_PUT)) begin
					val_q[i] <= wval_s1;
				end
			end
		end
	end

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("used count disagrees with valid entries");

	a_within_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(used_q) <= eff_cap)
		else $error("entries in use exceed capacity");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> (valid_q == '0) && (used_q == '0))
		else $error("capacity write did not empty the cache");

	a_hit_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit_oh))
		else $error("key stored in more than one entry");

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned TAIL_CYCLES = 20;

	typedef enum logic {
		ITEM_REQ,
		ITEM_CFG
	} item_kind_t;

	typedef struct {
		item_kind_t      kind;
		lkv_pkg::op_t    op;
		lkv_pkg::word_t  key;
		lkv_pkg::word_t  wval;
		int unsigned     gap;
		bit              drain_first;
		bit              hold_rx;
		lkv_pkg::cap_t   cap;
		int unsigned     rx_mode;
	} cache_op_t;

	typedef struct {
		logic            hit;
		lkv_pkg::word_t  read_value;
	} lookup_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lkv_req_if req_if ();
	lkv_rsp_if rsp_if ();
	lkv_cfg_if cfg_if ();

	logic           req_valid_q = 1'b0;
	lkv_pkg::op_t   req_op_q = lkv_pkg::OP_GET;
	lkv_pkg::word_t req_key_q = '0;
	lkv_pkg::word_t req_wval_q = '0;
	logic           req_hold_q = 1'b0;
	logic           rsp_ready_q = 1'b0;
	logic           cfg_valid_q = 1'b0;
	lkv_pkg::cap_t  cfg_cap_q = lkv_pkg::CAP_RESET;
	int unsigned rx_mode_q = 2;
	int unsigned hold_left = 0;

	assign req_if.valid       = req_valid_q;
	assign req_if.operation   = req_op_q;
	assign req_if.key         = req_key_q;
	assign req_if.write_value = req_wval_q;
	assign rsp_if.ready       = rsp_ready_q;
	assign cfg_if.valid       = cfg_valid_q;
	assign cfg_if.capacity    = cfg_cap_q;

	lru_key_value_cache #(
		.ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	initial forever #5 clk = ~clk;

	// shadow copy of the cache contents
	lkv_pkg::cap_t  cap_reg = lkv_pkg::CAP_RESET;
	bit             slot_used[SLOTS] = '{default: 1'b0};
	lkv_pkg::word_t slot_key[SLOTS];
	lkv_pkg::word_t slot_val[SLOTS];
	int             slot_age[SLOTS] = '{default: 0};
	int             fill_count = 0;

	cache_op_t      pending_ops[$];
	lookup_result_t pending_responses[$];
	int unsigned    fail_count = 0;

	function automatic int unsigned draw_idle(int unsigned mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return $urandom_range(0, 14);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
	endfunction

	function automatic void flag_error(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void load_capacity(lkv_pkg::cap_t c);
		int i;
		cap_reg = c;
		for (i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_age[i] = 0;
		end
		fill_count = 0;
	endfunction

	function automatic lookup_result_t lookup_and_update(lkv_pkg::op_t op,
			lkv_pkg::word_t k, lkv_pkg::word_t v);
		lookup_result_t r;
		int i;
		int found;
		int victim;
		int worst;
		int age0;
		int limit;
		r.hit = 1'b0;
		r.read_value = '0;
		found = -1;
		for (i = 0; i < SLOTS; i++)
			if (found < 0 && slot_used[i] && slot_key[i] == k)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (op == lkv_pkg::OP_GET)
				r.read_value = slot_val[found];
			else
				slot_val[found] = v;
			age0 = slot_age[found];
			for (i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_age[i] < age0)
					slot_age[i]++;
			slot_age[found] = 0;
		end else if (op == lkv_pkg::OP_PUT) begin
			victim = -1;
			limit = (cap_reg == 0) ? 1 : ((int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg));
			if (fill_count >= limit) begin
				worst = 0;
				// first slot holding the oldest age is the one replaced
				for (i = 0; i < SLOTS; i++)
					if (slot_used[i] && (victim < 0 || slot_age[i] > worst)) begin
						victim = i;
						worst = slot_age[i];
					end
				if (victim >= 0) begin
					slot_used[victim] = 1'b0;
					fill_count--;
				end
			end
			if (victim < 0)
				for (i = 0; i < SLOTS; i++)
					if (victim < 0 && !slot_used[i])
						victim = i;
			if (victim >= 0) begin
				for (i = 0; i < SLOTS; i++)
					if (slot_used[i])
						slot_age[i]++;
				slot_used[victim] = 1'b1;
				slot_key[victim] = k;
				slot_val[victim] = v;
				slot_age[victim] = 0;
				fill_count++;
			end
		end
		return r;
	endfunction

	function automatic void push_req(lkv_pkg::op_t op, lkv_pkg::word_t k,
			lkv_pkg::word_t v, int unsigned mode);
		cache_op_t it;
		it.kind = ITEM_REQ;
		it.op = op;
		it.key = k;
		it.wval = v;
		it.gap = draw_idle(mode);
		it.drain_first = 1'b0;
		it.hold_rx = 1'b0;
		it.cap = '0;
		it.rx_mode = 0;
		pending_ops.push_back(it);
	endfunction

	function automatic void push_cfg(lkv_pkg::cap_t c, int unsigned rx_mode);
		cache_op_t it;
		it.kind = ITEM_CFG;
		it.op = lkv_pkg::OP_GET;
		it.key = '0;
		it.wval = '0;
		it.gap = 0;
		it.drain_first = 1'b0;
		it.hold_rx = 1'b0;
		it.cap = c;
		it.rx_mode = rx_mode;
		pending_ops.push_back(it);
	endfunction

	// request and capacity driver
	int unsigned gap_left = 0;
	bit gap_armed = 1'b0;

	always @(posedge clk) begin : req_driver
		logic nv;
		logic ncv;
		logic fired;
		cache_op_t head;
		nv = req_valid_q;
		ncv = cfg_valid_q;
		if (arst_n) begin
			if (cfg_valid_q && cfg_if.ready) begin
				load_capacity(cfg_cap_q);
				ncv = 1'b0;
			end
			fired = req_valid_q && req_if.ready;
			if (fired) begin
				pending_responses.push_back(lookup_and_update(req_op_q, req_key_q, req_wval_q));
				nv = 1'b0;
			end
			if (!nv && !ncv && pending_ops.size() != 0) begin
				head = pending_ops[0];
				if (head.kind == ITEM_CFG) begin
					// capacity is only changed with nothing in flight
					if (pending_responses.size() == 0) begin
						void'(pending_ops.pop_front());
						ncv = 1'b1;
						cfg_cap_q <= head.cap;
						rx_mode_q <= head.rx_mode;
					end
				end else if (!(head.drain_first && pending_responses.size() != 0)) begin
					if (!gap_armed) begin
						gap_left = head.gap;
						gap_armed = 1'b1;
					end
					if (gap_left != 0)
						gap_left--;
					else begin
						void'(pending_ops.pop_front());
						gap_armed = 1'b0;
						nv = 1'b1;
						req_op_q <= head.op;
						req_key_q <= head.key;
						req_wval_q <= head.wval;
						req_hold_q <= head.hold_rx;
					end
				end
			end
		end
		req_valid_q <= nv;
		cfg_valid_q <= ncv;
	end

	// long receiver stall, started by a flagged request transfer
	always @(posedge clk) begin : long_hold
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (req_valid_q && req_if.ready && req_hold_q)
			hold_left <= HOLD_CYCLES;
	end

	int unsigned rsp_wait = 0;

	always @(posedge clk) begin : rsp_monitor
		logic nr;
		lookup_result_t e;
		nr = 1'b0;
		if (arst_n) begin
			if (rsp_if.valid && rsp_ready_q) begin
				if (pending_responses.size() == 0)
					flag_error($sformatf("unexpected response hit=%b value=%h",
						rsp_if.hit, rsp_if.read_value));
				else begin
					e = pending_responses.pop_front();
					if (rsp_if.hit !== e.hit || rsp_if.read_value !== e.read_value)
						flag_error($sformatf(
							"mismatch: expected hit=%b value=%h, got hit=%b value=%h",
							e.hit, e.read_value, rsp_if.hit, rsp_if.read_value));
				end
				rsp_wait = draw_idle(rx_mode_q);
			end
			if (hold_left != 0)
				nr = 1'b0;
			else if (rsp_wait != 0) begin
				rsp_wait--;
				nr = 1'b0;
			end else
				nr = 1'b1;
		end
		rsp_ready_q <= nr;
	end

	initial begin : stimulus
		lkv_pkg::word_t key_pool[24];
		lkv_pkg::cap_t phase_caps[11];
		int unsigned pool_n;
		int unsigned eff;
		int unsigned tx_mode;
		int p;
		int n;
		lkv_pkg::word_t k;
		phase_caps = '{5'd16, 5'd1, 5'd5, 5'd17, 5'd31, 5'd3, 5'd8, 5'd12, 5'd2, 5'd0, 5'd16};

		// directed: reset capacity, extreme keys and values
		push_req(lkv_pkg::OP_GET, 32'sh0000_0000, 32'sh1234_5678, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF, 2);
		push_req(lkv_pkg::OP_GET, 32'sh8000_0000, 32'sh0000_0000, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000, 2);
		push_req(lkv_pkg::OP_GET, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 2);
		push_req(lkv_pkg::OP_PUT, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 2);
		// a stored -1 must come back as a hit, distinct from a miss
		push_req(lkv_pkg::OP_GET, 32'shFFFF_FFFF, 32'sh0000_0000, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh8000_0000, 32'sh0000_0000, 2);
		push_req(lkv_pkg::OP_GET, 32'sh8000_0000, 32'sh5555_5555, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0001, 32'shAAAA_AAAA, 2);

		// capacity 2: LRU eviction order, write also clears the store
		push_cfg(5'd2, 2);
		push_req(lkv_pkg::OP_GET, 32'sh8000_0000, 32'sh0, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh0000_0011, 32'sh0000_0001, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh0000_0022, 32'sh0000_0002, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0011, 32'sh0, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh0000_0033, 32'sh0000_0003, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0022, 32'sh0, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0011, 32'sh0, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0033, 32'sh0, 2);

		// capacity 0 behaves as 1
		push_cfg(5'd0, 1);
		push_req(lkv_pkg::OP_PUT, 32'shFFFF_FFFF, 32'shAAAA_AAAA, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh0000_0000, 32'sh5555_5555, 2);
		push_req(lkv_pkg::OP_GET, 32'shFFFF_FFFF, 32'sh0, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0000, 32'sh0, 2);
		push_req(lkv_pkg::OP_PUT, 32'sh0000_0000, 32'sh7FFF_0001, 2);
		push_req(lkv_pkg::OP_GET, 32'sh0000_0000, 32'sh0, 2);

		// random phases: keys mostly from a pool sized near the capacity
		for (p = 0; p < 11; p++) begin
			tx_mode = p % 3;
			push_cfg(phase_caps[p], (p + 1) % 3);
			eff = (phase_caps[p] == 0) ? 1 :
				((int'(phase_caps[p]) > SLOTS) ? SLOTS : phase_caps[p]);
			pool_n = eff + $urandom_range(0, 5);
			if (pool_n > 2 && $urandom_range(0, 3) == 0)
				pool_n -= 2;
			for (n = 0; n < int'(pool_n); n++)
				case ($urandom_range(0, 9))
					0: key_pool[n] = 32'sh8000_0000;
					1: key_pool[n] = 32'sh7FFF_FFFF;
					2: key_pool[n] = 32'shFFFF_FFFF;
					default: key_pool[n] = lkv_pkg::word_t'($urandom());
				endcase
			for (n = 0; n < 95; n++) begin
				if ($urandom_range(0, 9) == 0)
					k = lkv_pkg::word_t'($urandom());
				else
					k = key_pool[$urandom_range(0, pool_n - 1)];
				push_req(lkv_pkg::op_t'($urandom_range(0, 1)), k,
					lkv_pkg::word_t'($urandom()), tx_mode);
				if ((p == 2 && n == 30) || (p == 7 && n == 50))
					pending_ops[pending_ops.size() - 1].hold_rx = 1'b1;
				if ((p == 4 || p == 8) && n == 40)
					pending_ops[pending_ops.size() - 1].drain_first = 1'b1;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_valid_q || cfg_valid_q
				|| pending_responses.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_responses.size() != 0)
			flag_error($sformatf("%0d responses never arrived", pending_responses.size()));

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ lru_key_value_cache.f @@
src/lkv_pkg.sv
src/lkv_ifs.sv
src/lru_key_value_cache.sv
dv/testbench.sv
